// ===== rtl/json_byte_tokenizer_defines.svh =====
// assertion macros for the json byte tokenizer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef JSON_BYTE_TOKENIZER_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define JBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define JBT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jbt_pkg.sv =====
// shared types, codes and keyword tables for the json byte tokenizer
// no dependencies
package jbt_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int RES_DEPTH       = 4;
  localparam int RES_PTR_W       = $clog2(RES_DEPTH);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_KEYWORD,
    MODE_HALTED
  } mode_t;

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COMMA    = 4'd4;
  localparam logic [3:0] KIND_COLON    = 4'd5;
  localparam logic [3:0] KIND_TRUE     = 4'd6;
  localparam logic [3:0] KIND_FALSE    = 4'd7;
  localparam logic [3:0] KIND_NULL     = 4'd8;
  localparam logic [3:0] KIND_INT      = 4'd9;
  localparam logic [3:0] KIND_DEC      = 4'd10;
  localparam logic [3:0] KIND_STR      = 4'd11;
  localparam logic [3:0] KIND_END      = 4'd12;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED = 2'd1;
  localparam logic [1:0] ERR_INVALID  = 2'd2;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [1:0]         err;
    logic               last;
  } result_t;

  // keyword text, one byte at a time
  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (id)
      KW_TRUE: begin
        case (idx)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (idx)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    logic [2:0] n;
    case (id)
      KW_FALSE: n = 3'd5;
      default:  n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] id);
    logic [3:0] k;
    case (id)
      KW_FALSE: k = KIND_FALSE;
      KW_NULL:  k = KIND_NULL;
      default:  k = KIND_TRUE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/json_byte_tokenizer.sv =====
// Streaming JSON tokenizer. One byte (or an end-of-text marker) enters per request on the
// in_ channel and yields zero, one or two token requests on the out_ channel, each with
// kind, start offset, length, error code and a last_of_run flag on the final result of
// that byte. A byte is taken every cycle as long as the four-entry result queue has room
// for two more results; a byte that ends a number and is itself a token or an invalid byte
// (or the end marker after a number) produces two results, which leave the queue one
// after the other. The results of a byte are registered in the queue before they reach
// the out_ channel. After an end token or an error the block halts: further bytes are
// still taken but ignored, until reset. Offsets count in OFFSET_BITS bits, saturate at
// the top and are reported in their low 32 bits.
// depends on jbt_pkg, jbt_lexer and jbt_res_queue
module json_byte_tokenizer #(
  parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  // token output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [31:0] out_token_start,
  output logic [31:0] out_token_length,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  logic             in_acc;
  logic             out_pop;
  logic             room2;
  logic [1:0]       res_cnt;
  jbt_pkg::result_t res0, res1, head;

  // hold off new bytes unless the queue can take two results
  assign in_stall = !room2;
  assign in_acc   = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;

  // per-byte mode update, results go straight into the queue
  jbt_lexer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .data_byte  (in_data_byte),
    .end_of_text(in_end_of_text),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  // result queue decouples the two sides
  jbt_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_pop),
    .head_valid(out_valid),
    .head      (head),
    .room2     (room2)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_error_code   = head.err;
  assign out_last_of_run  = head.last;

endmodule

// ===== rtl/jbt_lexer.sv =====
// lexer state machine: per-byte mode update and up to two results per byte
// depends on jbt_pkg
module jbt_lexer #(
  parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       data_byte,
  input  logic             end_of_text,
  output logic [1:0]       res_cnt,
  output jbt_pkg::result_t res0,
  output jbt_pkg::result_t res1
);

  localparam int FW = jbt_pkg::FIELD_W;

  jbt_pkg::mode_t         mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic                   esc_r, esc_nxt;
  logic                   dot_r, dot_nxt;
  logic [1:0]             kwid_r, kwid_nxt;
  logic [2:0]             kwidx_r, kwidx_nxt;

  // byte classes for the between-tokens decode
  logic       is_mark, is_space, is_kw, is_quote, is_num;
  logic [3:0] mark_kind;
  logic [1:0] kw_first;

  logic                   pos_sat;
  logic [2:0]             kw_next_idx;
  logic                   kw_match;
  logic [OFFSET_BITS-1:0] str_start, str_len;
  logic [OFFSET_BITS:0]   kw_tok_len;
  jbt_pkg::result_t       num_res, idle_res;
  logic                   idle_go, idle_has;

  always_comb begin
    is_mark   = 1'b1;
    mark_kind = jbt_pkg::KIND_LBRACE;
    case (data_byte)
      "{":     mark_kind = jbt_pkg::KIND_LBRACE;
      "}":     mark_kind = jbt_pkg::KIND_RBRACE;
      "[":     mark_kind = jbt_pkg::KIND_LBRACKET;
      "]":     mark_kind = jbt_pkg::KIND_RBRACKET;
      ",":     mark_kind = jbt_pkg::KIND_COMMA;
      ":":     mark_kind = jbt_pkg::KIND_COLON;
      default: is_mark = 1'b0;
    endcase
    is_space = (data_byte == " ") || (data_byte == 8'h09) || (data_byte == 8'h0A) ||
               (data_byte == 8'h0B) || (data_byte == 8'h0C) || (data_byte == 8'h0D);
    is_kw    = 1'b1;
    kw_first = jbt_pkg::KW_TRUE;
    case (data_byte)
      "t":     kw_first = jbt_pkg::KW_TRUE;
      "f":     kw_first = jbt_pkg::KW_FALSE;
      "n":     kw_first = jbt_pkg::KW_NULL;
      default: is_kw = 1'b0;
    endcase
    is_quote = (data_byte == "\"");
    is_num   = ((data_byte >= "0") && (data_byte <= "9")) ||
               (data_byte == "-") || (data_byte == ".");
  end

  assign pos_sat     = (pos_r == {OFFSET_BITS{1'b1}});
  assign kw_next_idx = kwidx_r + 3'd1;
  assign kw_match    = (kwidx_r < jbt_pkg::kw_len(kwid_r)) &&
                       (data_byte == jbt_pkg::kw_char(kwid_r, kwidx_r));
  assign str_start   = (start_r != {OFFSET_BITS{1'b1}}) ? start_r + 1'b1 : start_r;
  assign str_len     = (pos_r > start_r) ? pos_r - start_r - 1'b1 : '0;
  assign kw_tok_len  = {1'b0, pos_r} - {1'b0, start_r} + 1'b1;

  always_comb begin
    num_res.kind   = dot_r ? jbt_pkg::KIND_DEC : jbt_pkg::KIND_INT;
    num_res.start  = FW'(start_r);
    num_res.length = FW'(pos_r - start_r);
    num_res.err    = jbt_pkg::ERR_NONE;
    num_res.last   = 1'b0;
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    esc_nxt   = esc_r;
    dot_nxt   = dot_r;
    kwid_nxt  = kwid_r;
    kwidx_nxt = kwidx_r;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    idle_go   = 1'b0;
    idle_has  = 1'b0;
    idle_res  = '0;

    if (acc && (mode_r != jbt_pkg::MODE_HALTED)) begin
      if (end_of_text) begin
        mode_nxt = jbt_pkg::MODE_HALTED;
        case (mode_r)
          jbt_pkg::MODE_STRING: begin
            res0.start = FW'(start_r);
            res0.err   = jbt_pkg::ERR_UNCLOSED;
            res_cnt    = 2'd1;
          end
          jbt_pkg::MODE_KEYWORD: begin
            res0.start = FW'(start_r);
            res0.err   = jbt_pkg::ERR_INVALID;
            res_cnt    = 2'd1;
          end
          jbt_pkg::MODE_NUMBER: begin
            res0       = num_res;
            res1.kind  = jbt_pkg::KIND_END;
            res1.start = FW'(pos_r);
            res_cnt    = 2'd2;
          end
          default: begin
            res0.kind  = jbt_pkg::KIND_END;
            res0.start = FW'(pos_r);
            res_cnt    = 2'd1;
          end
        endcase
      end else begin
        if (!pos_sat) begin
          pos_nxt = pos_r + 1'b1;
        end
        case (mode_r)
          jbt_pkg::MODE_STRING: begin
            if (data_byte == 8'h0A) begin
              res0.start = FW'(start_r);
              res0.err   = jbt_pkg::ERR_UNCLOSED;
              res_cnt    = 2'd1;
              mode_nxt   = jbt_pkg::MODE_HALTED;
            end else if (!esc_r && is_quote) begin
              res0.kind   = jbt_pkg::KIND_STR;
              res0.start  = FW'(str_start);
              res0.length = FW'(str_len);
              res_cnt     = 2'd1;
              mode_nxt    = jbt_pkg::MODE_IDLE;
            end else begin
              esc_nxt = !esc_r && (data_byte == "\\");
            end
          end
          jbt_pkg::MODE_KEYWORD: begin
            if (kw_match) begin
              kwidx_nxt = kw_next_idx;
              if (kw_next_idx == jbt_pkg::kw_len(kwid_r)) begin
                res0.kind   = jbt_pkg::kw_kind(kwid_r);
                res0.start  = FW'(start_r);
                res0.length = FW'(kw_tok_len);
                res_cnt     = 2'd1;
                mode_nxt    = jbt_pkg::MODE_IDLE;
              end
            end else begin
              res0.start = FW'(start_r);
              res0.err   = jbt_pkg::ERR_INVALID;
              res_cnt    = 2'd1;
              mode_nxt   = jbt_pkg::MODE_HALTED;
            end
          end
          jbt_pkg::MODE_NUMBER: begin
            if (is_num) begin
              if (data_byte == ".") begin
                dot_nxt = 1'b1;
              end
            end else begin
              // number ends here, then the byte starts whatever follows
              res0     = num_res;
              res_cnt  = 2'd1;
              mode_nxt = jbt_pkg::MODE_IDLE;
              idle_go  = 1'b1;
            end
          end
          default: begin
            idle_go = 1'b1;
          end
        endcase

        if (idle_go) begin
          idle_res.start = FW'(pos_r);
          if (is_mark) begin
            idle_has        = 1'b1;
            idle_res.kind   = mark_kind;
            idle_res.length = FW'(1);
          end else if (is_space) begin
            idle_has = 1'b0;
          end else if (is_kw) begin
            mode_nxt  = jbt_pkg::MODE_KEYWORD;
            kwid_nxt  = kw_first;
            kwidx_nxt = 3'd1;
            start_nxt = pos_r;
          end else if (is_quote) begin
            mode_nxt  = jbt_pkg::MODE_STRING;
            esc_nxt   = 1'b0;
            start_nxt = pos_r;
          end else if (is_num) begin
            mode_nxt  = jbt_pkg::MODE_NUMBER;
            dot_nxt   = (data_byte == ".");
            start_nxt = pos_r;
          end else begin
            idle_has     = 1'b1;
            idle_res.err = jbt_pkg::ERR_INVALID;
            mode_nxt     = jbt_pkg::MODE_HALTED;
          end
          if (idle_has) begin
            if (res_cnt == 2'd0) begin
              res0    = idle_res;
              res_cnt = 2'd1;
            end else begin
              res1    = idle_res;
              res_cnt = 2'd2;
            end
          end
        end
      end
    end

    // flag the final result of this byte
    if (res_cnt == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jbt_pkg::MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      esc_r   <= 1'b0;
      dot_r   <= 1'b0;
      kwid_r  <= 2'd0;
      kwidx_r <= 3'd0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      esc_r   <= esc_nxt;
      dot_r   <= dot_nxt;
      kwid_r  <= kwid_nxt;
      kwidx_r <= kwidx_nxt;
    end
  end

endmodule

// ===== rtl/jbt_res_queue.sv =====
// result queue: takes up to two results a cycle, hands out one a cycle while pop is raised
// depends on jbt_pkg
module jbt_res_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  jbt_pkg::result_t push0,
  input  jbt_pkg::result_t push1,
  input  logic             pop,
  output logic             head_valid,
  output jbt_pkg::result_t head,
  output logic             room2
);

  localparam int PW = jbt_pkg::RES_PTR_W;

  jbt_pkg::result_t mem_r [jbt_pkg::RES_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic [PW-1:0]    wr_ptr_1;

  assign wr_ptr_1   = wr_ptr_r + 1'b1;
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room2      = (cnt_r <= (PW+1)'(jbt_pkg::RES_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push_cnt) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/jbt_checker.sv =====
// port-level checks on the json byte tokenizer, bound to the top level
// depends on json_byte_tokenizer_defines.svh, jbt_pkg and json_byte_tokenizer
`include "json_byte_tokenizer_defines.svh"

module jbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_token_kind,
  input logic [31:0] out_token_start,
  input logic [31:0] out_token_length,
  input logic [1:0]  out_error_code,
  input logic        out_last_of_run
);

  logic [70:0] out_payload;
  logic        is_err, err_ok;
  logic        is_end, end_ok;
  logic        is_mark;

  assign out_payload = {out_token_kind, out_token_start, out_token_length,
                        out_error_code, out_last_of_run};

  // error requests carry kind zero, no length, and close the run
  assign is_err = out_valid && (out_error_code != jbt_pkg::ERR_NONE);
  assign err_ok = (out_error_code <= jbt_pkg::ERR_INVALID) &&
                  (out_token_kind == jbt_pkg::KIND_LBRACE) &&
                  (out_token_length == 32'd0) && out_last_of_run;

  assign is_end = out_valid && (out_token_kind == jbt_pkg::KIND_END);
  assign end_ok = (out_token_length == 32'd0) && (out_error_code == jbt_pkg::ERR_NONE) &&
                  out_last_of_run;

  assign is_mark = out_valid && (out_error_code == jbt_pkg::ERR_NONE) &&
                   (out_token_kind <= jbt_pkg::KIND_COLON);

  // a stalled token request stays and keeps its payload
  `JBT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload), "stalled token request changed")

  // an error closes the run with kind zero and no length
  `JBT_ASSERT_IMP(a_err_shape, is_err, err_ok, "bad error request")

  // an end token has no length, no error and closes the run
  `JBT_ASSERT_IMP(a_end_shape, is_end, end_ok, "bad end request")

  // punctuation tokens are one byte long
  `JBT_ASSERT_IMP(a_mark_len, is_mark, out_token_length == 32'd1, "punctuation length not one")

  // an empty result side never holds off bytes
  `JBT_ASSERT_IMP(a_empty_no_stall, !out_valid, !in_stall, "byte stalled with no pending token")

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_token_kind  (out_token_kind),
  .out_token_start (out_token_start),
  .out_token_length(out_token_length),
  .out_error_code  (out_error_code),
  .out_last_of_run (out_last_of_run)
);

// ===== tb/tb_json_byte_tokenizer.sv =====
// testbench for json_byte_tokenizer: feeds directed and random JSON text, one byte per request,
// predicts every token, end marker and error, and checks the result requests in order
// depends on jbt_pkg and the json_byte_tokenizer rtl
module tb_json_byte_tokenizer;

  // stimulus size and run bounds
  localparam int RANDOM_BYTES    = 800;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_WAIT        = 17;
  localparam int HOLD_OFF_AT     = 120;
  localparam int HOLD_OFF_CYCLES = 300;

  // byte values the lexer treats specially
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // error results carry kind zero
  localparam logic [3:0] KIND_OF_ERROR = jbt_pkg::KIND_LBRACE;

  // how the text of one run is brought to a stop; the block halts after any of them
  typedef enum int {
    STOP_END_IDLE,
    STOP_END_NUMBER,
    STOP_END_IN_STRING,
    STOP_NEWLINE_IN_STRING,
    STOP_END_IN_KEYWORD,
    STOP_BROKEN_KEYWORD,
    STOP_INVALID_BYTE
  } stop_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_token_kind;
  logic [31:0] out_token_start;
  logic [31:0] out_token_length;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;

  json_byte_tokenizer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // bytes waiting to be sent, filled once before reset is released
  text_req_t         text_queue[$];
  // tokens the lexer is expected to emit, oldest first
  jbt_pkg::result_t  predicted_tokens[$];
  int                mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // token predictor: its own copy of the lexer state, advanced once per
  // accepted byte request
  // ---------------------------------------------------------------------------
  string      keyword_text [3] = '{"true", "false", "null"};
  logic [3:0] keyword_token [3] = '{jbt_pkg::KIND_TRUE, jbt_pkg::KIND_FALSE,
                                    jbt_pkg::KIND_NULL};

  jbt_pkg::mode_t   lex_mode = jbt_pkg::MODE_IDLE;
  logic [31:0]      lex_pos = 32'd0;
  logic [31:0]      lex_tok_start = 32'd0;
  logic             lex_escape = 1'b0;
  logic             lex_dot = 1'b0;
  logic [1:0]       lex_kw = jbt_pkg::KW_TRUE;
  logic [2:0]       lex_kw_idx = 3'd0;
  // at most two tokens come out of one byte
  jbt_pkg::result_t step_buf [2];
  int               step_n;

  function automatic logic is_num_byte(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_ZERO + 8'd9) || b == CH_MINUS || b == CH_DOT;
  endfunction

  function automatic void add_token(input logic [3:0] kind, input logic [31:0] start,
                                    input logic [31:0] length, input logic [1:0] err);
    jbt_pkg::result_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = length;
    r.err    = err;
    r.last   = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void halt_on_error(input logic [31:0] where, input logic [1:0] err);
    lex_mode = jbt_pkg::MODE_HALTED;
    add_token(KIND_OF_ERROR, where, 32'd0, err);
  endfunction

  function automatic void close_number();
    add_token(lex_dot ? jbt_pkg::KIND_DEC : jbt_pkg::KIND_INT, lex_tok_start,
              lex_pos - lex_tok_start, jbt_pkg::ERR_NONE);
    lex_mode = jbt_pkg::MODE_IDLE;
  endfunction

  // a byte seen between tokens: a mark, whitespace, or the start of a longer token
  function automatic void lex_between_tokens(input logic [7:0] b);
    case (b)
      "{": add_token(jbt_pkg::KIND_LBRACE, lex_pos, 32'd1, jbt_pkg::ERR_NONE);
      "}": add_token(jbt_pkg::KIND_RBRACE, lex_pos, 32'd1, jbt_pkg::ERR_NONE);
      "[": add_token(jbt_pkg::KIND_LBRACKET, lex_pos, 32'd1, jbt_pkg::ERR_NONE);
      "]": add_token(jbt_pkg::KIND_RBRACKET, lex_pos, 32'd1, jbt_pkg::ERR_NONE);
      ",": add_token(jbt_pkg::KIND_COMMA, lex_pos, 32'd1, jbt_pkg::ERR_NONE);
      ":": add_token(jbt_pkg::KIND_COLON, lex_pos, 32'd1, jbt_pkg::ERR_NONE);
      CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ;
      "t", "f", "n": begin
        lex_mode      = jbt_pkg::MODE_KEYWORD;
        lex_kw        = (b == "t") ? jbt_pkg::KW_TRUE :
                        (b == "f") ? jbt_pkg::KW_FALSE : jbt_pkg::KW_NULL;
        lex_kw_idx    = 3'd1;
        lex_tok_start = lex_pos;
      end
      CH_QUOTE: begin
        lex_mode      = jbt_pkg::MODE_STRING;
        lex_escape    = 1'b0;
        lex_tok_start = lex_pos;
      end
      default: begin
        if (is_num_byte(b)) begin
          lex_mode      = jbt_pkg::MODE_NUMBER;
          lex_dot       = (b == CH_DOT);
          lex_tok_start = lex_pos;
        end else begin
          halt_on_error(lex_pos, jbt_pkg::ERR_INVALID);
        end
      end
    endcase
  endfunction

  function automatic void lex_step(input logic [7:0] b, input logic eot);
    int klen;
    int i;
    step_n = 0;
    if (lex_mode == jbt_pkg::MODE_HALTED) return;
    if (eot) begin
      if (lex_mode == jbt_pkg::MODE_STRING) begin
        halt_on_error(lex_tok_start, jbt_pkg::ERR_UNCLOSED);
      end else if (lex_mode == jbt_pkg::MODE_KEYWORD) begin
        halt_on_error(lex_tok_start, jbt_pkg::ERR_INVALID);
      end else begin
        if (lex_mode == jbt_pkg::MODE_NUMBER) close_number();
        add_token(jbt_pkg::KIND_END, lex_pos, 32'd0, jbt_pkg::ERR_NONE);
        lex_mode = jbt_pkg::MODE_HALTED;
      end
    end else begin
      case (lex_mode)
        jbt_pkg::MODE_STRING: begin
          if (b == CH_LF) begin
            halt_on_error(lex_tok_start, jbt_pkg::ERR_UNCLOSED);
          end else if (!lex_escape && b == CH_QUOTE) begin
            // text starts after the opening quote and stops before the closing one
            add_token(jbt_pkg::KIND_STR,
                      (lex_tok_start != '1) ? lex_tok_start + 32'd1 : lex_tok_start,
                      (lex_pos > lex_tok_start) ? lex_pos - lex_tok_start - 32'd1 : 32'd0,
                      jbt_pkg::ERR_NONE);
            lex_mode = jbt_pkg::MODE_IDLE;
          end else begin
            lex_escape = !lex_escape && b == CH_BSLASH;
          end
        end
        jbt_pkg::MODE_KEYWORD: begin
          klen = keyword_text[lex_kw].len();
          if (lex_kw_idx < klen && b == keyword_text[lex_kw][lex_kw_idx]) begin
            lex_kw_idx = lex_kw_idx + 3'd1;
            if (lex_kw_idx == klen) begin
              add_token(keyword_token[lex_kw], lex_tok_start, lex_pos - lex_tok_start + 32'd1,
                        jbt_pkg::ERR_NONE);
              lex_mode = jbt_pkg::MODE_IDLE;
            end
          end else begin
            halt_on_error(lex_tok_start, jbt_pkg::ERR_INVALID);
          end
        end
        jbt_pkg::MODE_NUMBER: begin
          if (is_num_byte(b)) begin
            if (b == CH_DOT) lex_dot = 1'b1;
          end else begin
            // the number ends here and the byte is lexed again on its own
            close_number();
            lex_between_tokens(b);
          end
        end
        default: lex_between_tokens(b);
      endcase
      // offsets saturate at the top of the counter
      if (lex_pos != '1) lex_pos = lex_pos + 32'd1;
    end
    if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
    for (i = 0; i < step_n; i++) predicted_tokens.push_back(step_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------------
  function automatic void put_byte(input logic [7:0] b);
    text_req_t r;
    r.data = b;
    r.eot  = 1'b0;
    text_queue.push_back(r);
  endfunction

  // the byte beside an end marker is random, it must be ignored
  function automatic void put_end_marker();
    text_req_t r;
    r.data = 8'($urandom_range(0, 255));
    r.eot  = 1'b1;
    text_queue.push_back(r);
  endfunction

  function automatic void put_space();
    case ($urandom_range(0, 5))
      0: put_byte(CH_SP);
      1: put_byte(CH_TAB);
      2: put_byte(CH_LF);
      3: put_byte(CH_VT);
      4: put_byte(CH_FF);
      default: put_byte(CH_CR);
    endcase
  endfunction

  function automatic void put_mark();
    case ($urandom_range(0, 5))
      0: put_byte("{");
      1: put_byte("}");
      2: put_byte("[");
      3: put_byte("]");
      4: put_byte(",");
      default: put_byte(":");
    endcase
  endfunction

  function automatic void put_keyword_prefix(input logic [1:0] id, input int count);
    int i;
    for (i = 0; i < count; i++) put_byte(keyword_text[id][i]);
  endfunction

  // string content never holds a bare newline; escapes pair a backslash with any other byte
  function automatic void put_string_body(input int units);
    logic [7:0] b;
    int i;
    for (i = 0; i < units; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        put_byte(CH_BSLASH);
        b = ($urandom_range(0, 2) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
        if (b == CH_LF) b = CH_BSLASH;
        put_byte(b);
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF) b = "x";
        put_byte(b);
      end
    end
  endfunction

  function automatic void put_number();
    int len;
    int pick;
    int i;
    logic digits_only;
    len = $urandom_range(1, 6);
    digits_only = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i++) begin
      pick = digits_only ? $urandom_range(0, 9) : $urandom_range(0, 11);
      if (pick < 10) put_byte(CH_ZERO + 8'(pick));
      else if (pick == 10) put_byte(CH_MINUS);
      else put_byte(CH_DOT);
    end
  endfunction

  task automatic build_text();
    // every mark and keyword, an escaped quote, numbers ended by a mark, a quote and a keyword
    string opening;
    stop_kind_t stop;
    logic [1:0] id;
    logic [7:0] b;
    logic ok;
    int p;
    int i;
    int tail_n;
    opening = "{-.5,0\"\\\"\"7true[null:false]}";
    for (i = 0; i < opening.len(); i++) put_byte(opening[i]);

    // well-formed token stream with random content and random spacing
    while (text_queue.size() < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2: put_mark();
        3: begin
          id = 2'($urandom_range(0, 2));
          put_keyword_prefix(id, keyword_text[id].len());
        end
        4, 5: begin
          put_byte(CH_QUOTE);
          put_string_body(($urandom_range(0, 7) == 0) ? $urandom_range(8, 16)
                                                        : $urandom_range(0, 5));
          put_byte(CH_QUOTE);
        end
        default: put_number();
      endcase
      if ($urandom_range(0, 2) == 0) put_space();
    end

    // the block halts on the first end or error, so each run picks one way to stop
    stop = stop_kind_t'($urandom_range(0, 6));
    id = 2'($urandom_range(0, 2));
    p = $urandom_range(1, keyword_text[id].len() - 1);
    case (stop)
      STOP_END_IDLE: put_end_marker();
      STOP_END_NUMBER: begin
        put_number();
        put_end_marker();
      end
      STOP_END_IN_STRING: begin
        put_byte(CH_QUOTE);
        put_string_body($urandom_range(0, 4));
        put_end_marker();
      end
      STOP_NEWLINE_IN_STRING: begin
        put_byte(CH_QUOTE);
        put_string_body($urandom_range(0, 4));
        // an escaped newline still breaks the string
        if ($urandom_range(0, 1) == 1) put_byte(CH_BSLASH);
        put_byte(CH_LF);
      end
      STOP_END_IN_KEYWORD: begin
        put_keyword_prefix(id, p);
        put_end_marker();
      end
      STOP_BROKEN_KEYWORD: begin
        put_keyword_prefix(id, p);
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == keyword_text[id][p]);
        put_byte(b);
      end
      default: begin
        // sometimes a number runs straight into the bad byte
        if ($urandom_range(0, 1) == 1) put_number();
        do begin
          b = 8'($urandom_range(0, 255));
          case (b)
            "{", "}", "[", "]", ",", ":", CH_QUOTE, "t", "f", "n",
            CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ok = 1'b0;
            default: ok = !is_num_byte(b);
          endcase
        end while (!ok);
        put_byte(b);
      end
    endcase

    // once halted, bytes and end markers are taken but yield nothing
    tail_n = $urandom_range(2, 8);
    for (i = 0; i < tail_n; i++) begin
      if ($urandom_range(0, 1) == 1) put_end_marker();
      else put_byte(8'($urandom_range(0, 255)));
    end
    put_end_marker();
  endtask

  // pause length for the next request; each side flips in and out of back-to-back stretches
  function automatic int draw_wait(inout logic burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // ---------------------------------------------------------------------------
  // byte driver: presents queued bytes, holds them while stalled, and runs the
  // predictor on every accepted request
  // ---------------------------------------------------------------------------
  int   send_wait = 0;
  logic send_burst = 1'b0;

  always @(posedge clk) begin : drive_bytes
    int gap;
    text_req_t req;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_data_byte   <= 8'h00;
      in_end_of_text <= 1'b0;
      send_wait      <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        // request accepted at this edge
        lex_step(in_data_byte, in_end_of_text);
        gap = draw_wait(send_burst);
      end else begin
        gap = send_wait;
      end
      if (gap == 0 && text_queue.size() > 0) begin
        req = text_queue.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= req.data;
        in_end_of_text <= req.eot;
        send_wait      <= 0;
      end else begin
        in_valid  <= 1'b0;
        send_wait <= (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result pacing: a random stall after each taken token, plus one long
  // hold-off that lets the result queue fill and push back on the byte side
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  int   results_taken = 0;
  logic take_burst = 1'b0;

  always @(posedge clk) begin : pace_results
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (results_taken == HOLD_OFF_AT) w = HOLD_OFF_CYCLES;
      else w = draw_wait(take_burst);
      results_taken <= results_taken + 1;
      hold_left     <= w;
      out_stall     <= (w != 0);
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // token checker: every taken result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    jbt_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d error %0d",
               out_token_kind, out_token_start, out_token_length, out_error_code);
        mismatch_count++;
      end else begin
        want = predicted_tokens.pop_front();
        if (out_token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_token_kind);
          mismatch_count++;
        end
        if (out_token_start !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, out_token_start);
          mismatch_count++;
        end
        if (out_token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, out_token_length);
          mismatch_count++;
        end
        if (out_error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_error_code);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: build the text, reset once, wait for the stream to drain
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int cycles;
    logic timed_out;
    build_text();
    cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (cycles < CYCLE_LIMIT &&
           (text_queue.size() != 0 || in_valid || predicted_tokens.size() != 0)) begin
      @(posedge clk);
      cycles++;
    end
    timed_out = (cycles >= CYCLE_LIMIT);
    // go on clocking so that any stray token still shows up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (timed_out) begin
      $error("run timed out after %0d cycles", cycles);
    end
    if (predicted_tokens.size() != 0) begin
      $error("%0d predicted tokens never arrived", predicted_tokens.size());
      mismatch_count++;
    end
    if (!timed_out && mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== json_byte_tokenizer.f =====
+incdir+rtl
rtl/jbt_pkg.sv
rtl/jbt_lexer.sv
rtl/jbt_res_queue.sv
rtl/json_byte_tokenizer.sv
rtl/jbt_checker.sv
tb/tb_json_byte_tokenizer.sv
